FILE: rtl/rsplit_pkg.sv
package rsplit_pkg;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [15:0] ONE_Q12   = 16'd4096;
    localparam logic [15:0] COEF_FULL = 16'd64881;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNOFF_EXP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FROZEN_TEMP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FROZEN_RATIO = 2'd3;

    // Register reset values
    localparam logic [15:0]        RST_RUNOFF_EXP   = 16'd8192;
    localparam logic [23:0]        RST_MAX_RAIN     = 24'd4096000;
    localparam logic signed [15:0] RST_FROZEN_TEMP  = 16'sd0;
    localparam logic [15:0]        RST_FROZEN_RATIO = 16'd32768;

    // Iterations of the divider, logarithm and exponential units
    localparam int NSTEP = 16;

    typedef struct packed {
        logic [15:0]        exp_eff;
        logic [23:0]        mrd;
        logic signed [15:0] ft;
        logic [15:0]        ratio;
    } t_cfg;

    typedef struct packed {
        logic [23:0]        net_precip;
        logic [23:0]        depression_storage;
        logic [15:0]        runoff_coefficient;
        logic signed [15:0] soil_temperature;
        logic [23:0]        profile_water;
        logic [23:0]        saturation_capacity;
    } t_cell;

    // Front end to logarithm
    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic [15:0] coef;
        logic [16:0] m;
        logic [15:0] alpha;
        logic        frz;
        logic        hzero;
    } t_mid;

    // Logarithm to exponential
    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic [15:0] coef;
        logic        frz;
        logic        hzero;
        logic        m_zero;
        logic        m_one;
        logic [24:0] p;
    } t_lp;

    typedef struct packed {
        logic [24:0] excess_precip;
        logic [24:0] infiltration;
        logic        frozen;
    } t_res;

endpackage

FILE: rtl/rsplit_cell_if.sv
interface rsplit_cell_if;
    logic               valid;
    logic               ready;
    logic [23:0]        net_precip;
    logic [23:0]        depression_storage;
    logic [15:0]        runoff_coefficient;
    logic signed [15:0] soil_temperature;
    logic [23:0]        profile_water;
    logic [23:0]        saturation_capacity;

    modport source (
        output valid, net_precip, depression_storage, runoff_coefficient,
               soil_temperature, profile_water, saturation_capacity,
        input  ready
    );
    modport sink (
        input  valid, net_precip, depression_storage, runoff_coefficient,
               soil_temperature, profile_water, saturation_capacity,
        output ready
    );
endinterface

FILE: rtl/rsplit_split_if.sv
interface rsplit_split_if;
    logic        valid;
    logic        ready;
    logic [24:0] excess_precip;
    logic [24:0] infiltration;
    logic        frozen;

    modport source (
        output valid, excess_precip, infiltration, frozen,
        input  ready
    );
    modport sink (
        input  valid, excess_precip, infiltration, frozen,
        output ready
    );
endinterface

FILE: rtl/runoff_infiltration_split_core.sv
// Throughput: one transaction per cycle unless o_split stalls; the 58 pipeline stages
// each hold one item (16 divider steps, 16 squaring steps, 16 factor multiplies and
// the glue stages).
// A stalled output holds only the stages behind a full one; empty stages keep filling.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores every
// configuration register to its default.
module runoff_infiltration_split_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    rsplit_cell_if.sink                               i_cell,
    rsplit_split_if.source                            o_split,
    input  logic                                      i_cfg_we,
    input  logic [rsplit_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [rsplit_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import rsplit_pkg::*;

    logic [15:0]        r_exp;
    logic [23:0]        r_mrd;
    logic signed [15:0] r_ft;
    logic [15:0]        r_ratio;
    t_cfg  w_cfg;
    t_cell w_cell;
    t_mid  w_mid;
    t_lp   w_lp;
    t_res  w_res;
    logic  w_mid_v, w_mid_r, w_lp_v, w_lp_r;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp   <= RST_RUNOFF_EXP;
            r_mrd   <= RST_MAX_RAIN;
            r_ft    <= RST_FROZEN_TEMP;
            r_ratio <= RST_FROZEN_RATIO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RUNOFF_EXP:   r_exp   <= i_cfg_data[15:0];
                CFG_MAX_RAIN:     r_mrd   <= i_cfg_data[23:0];
                CFG_FROZEN_TEMP:  r_ft    <= i_cfg_data[15:0];
                CFG_FROZEN_RATIO: r_ratio <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Exponent below one counts as one
    always_comb begin
        w_cfg.exp_eff = (r_exp < ONE_Q12) ? ONE_Q12 : r_exp;
        w_cfg.mrd     = r_mrd;
        w_cfg.ft      = r_ft;
        w_cfg.ratio   = r_ratio;
    end

    always_comb begin
        w_cell.net_precip          = i_cell.net_precip;
        w_cell.depression_storage  = i_cell.depression_storage;
        w_cell.runoff_coefficient  = i_cell.runoff_coefficient;
        w_cell.soil_temperature    = i_cell.soil_temperature;
        w_cell.profile_water       = i_cell.profile_water;
        w_cell.saturation_capacity = i_cell.saturation_capacity;
    end

    rsplit_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_cell.valid),
        .o_ready (i_cell.ready),
        .i_cell  (w_cell),
        .o_valid (w_mid_v),
        .i_ready (w_mid_r),
        .o_mid   (w_mid)
    );

    rsplit_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_v),
        .o_ready (w_mid_r),
        .i_mid   (w_mid),
        .o_valid (w_lp_v),
        .i_ready (w_lp_r),
        .o_lp    (w_lp)
    );

    rsplit_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lp_v),
        .o_ready (w_lp_r),
        .i_lp    (w_lp),
        .o_valid (o_split.valid),
        .i_ready (o_split.ready),
        .o_res   (w_res)
    );

    assign o_split.excess_precip = w_res.excess_precip;
    assign o_split.infiltration  = w_res.infiltration;
    assign o_split.frozen        = w_res.frozen;

endmodule

FILE: rtl/rsplit_front.sv
module rsplit_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsplit_pkg::t_cfg   i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  rsplit_pkg::t_cell  i_cell,
    output logic               o_valid,
    input  logic               i_ready,
    output rsplit_pkg::t_mid   o_mid
);
    import rsplit_pkg::*;

    localparam int NST = NSTEP + 3;

    typedef struct packed {
        logic [24:0]        h;
        logic [23:0]        rain;
        logic [15:0]        coef;
        logic signed [15:0] temp;
        logic [23:0]        water;
        logic [23:0]        sat;
    } t_fa;

    typedef struct packed {
        logic [24:0]        h;
        logic [23:0]        rain;
        logic [15:0]        coef;
        logic signed [15:0] temp;
        logic [23:0]        water;
        logic [23:0]        sat;
        logic [40:0]        num;
        logic               big;
        logic               deep;
    } t_fb;

    typedef struct packed {
        logic [24:0]        h;
        logic [23:0]        rain;
        logic [15:0]        coef;
        logic signed [15:0] temp;
        logic [23:0]        sat;
        logic               big;
        logic               deep;
        logic [23:0]        rem_m;
        logic [23:0]        rem_a;
        logic [15:0]        q_m;
        logic [15:0]        q_a;
        logic [15:0]        nlo;
    } t_dv;

    // One restoring step of both dividers: moisture and exponent fall-off
    function automatic t_dv div_step(input t_dv d, input logic [23:0] mrd);
        t_dv         o;
        logic [24:0] tm;
        logic [24:0] ta;
        o  = d;
        tm = {d.rem_m, 1'b0};
        ta = {d.rem_a, d.nlo[15]};
        if (tm >= {1'b0, d.sat}) begin
            o.rem_m = 24'(tm - {1'b0, d.sat});
            o.q_m   = {d.q_m[14:0], 1'b1};
        end else begin
            o.rem_m = tm[23:0];
            o.q_m   = {d.q_m[14:0], 1'b0};
        end
        if (ta >= {1'b0, mrd}) begin
            o.rem_a = 24'(ta - {1'b0, mrd});
            o.q_a   = {d.q_a[14:0], 1'b1};
        end else begin
            o.rem_a = ta[23:0];
            o.q_a   = {d.q_a[14:0], 1'b0};
        end
        o.nlo = {d.nlo[14:0], 1'b0};
        return o;
    endfunction

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_load;
    t_fa  r_a, n_a;
    t_fb  r_b, n_b;
    t_dv  r_dv [NSTEP];
    t_dv  n_dv [NSTEP];
    t_dv  w_init;
    t_mid r_f, n_f;
    logic [15:0] w_kd;

    // Stage moves when empty or when the next one moves
    always_comb begin
        w_load[NST-1] = !r_v[NST-1] || i_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_load[i] = !r_v[i] || w_load[i+1];
        end
    end

    assign o_ready = w_load[0];
    assign o_valid = r_v[NST-1];
    assign o_mid   = r_f;

    // Total water and operand capture
    always_comb begin
        n_a.h     = {1'b0, i_cell.net_precip} + {1'b0, i_cell.depression_storage};
        n_a.rain  = i_cell.net_precip;
        n_a.coef  = i_cell.runoff_coefficient;
        n_a.temp  = i_cell.soil_temperature;
        n_a.water = i_cell.profile_water;
        n_a.sat   = i_cell.saturation_capacity;
    end

    // Exponent numerator (k - 1) * h and divider guards
    assign w_kd = i_cfg.exp_eff - ONE_Q12;
    always_comb begin
        n_b.h     = r_a.h;
        n_b.rain  = r_a.rain;
        n_b.coef  = r_a.coef;
        n_b.temp  = r_a.temp;
        n_b.water = r_a.water;
        n_b.sat   = r_a.sat;
        n_b.num   = 41'(w_kd) * 41'(r_a.h);
        n_b.big   = r_a.water >= r_a.sat;
        n_b.deep  = r_a.h >= {1'b0, i_cfg.mrd};
    end

    // Seed both dividers, then one quotient bit per stage
    always_comb begin
        w_init.h     = r_b.h;
        w_init.rain  = r_b.rain;
        w_init.coef  = r_b.coef;
        w_init.temp  = r_b.temp;
        w_init.sat   = r_b.sat;
        w_init.big   = r_b.big;
        w_init.deep  = r_b.deep;
        w_init.rem_m = r_b.water;
        w_init.rem_a = r_b.num[39:16];
        w_init.q_m   = '0;
        w_init.q_a   = '0;
        w_init.nlo   = r_b.num[15:0];
        n_dv[0] = div_step(w_init, i_cfg.mrd);
        for (int i = 1; i < NSTEP; i++) begin
            n_dv[i] = div_step(r_dv[i-1], i_cfg.mrd);
        end
    end

    // Moisture fraction, exponent and frozen-soil decision
    always_comb begin
        n_f.h     = r_dv[NSTEP-1].h;
        n_f.rain  = r_dv[NSTEP-1].rain;
        n_f.coef  = r_dv[NSTEP-1].coef;
        n_f.m     = r_dv[NSTEP-1].big ? ONE_Q16 : {1'b0, r_dv[NSTEP-1].q_m};
        n_f.alpha = r_dv[NSTEP-1].deep ? ONE_Q12 : i_cfg.exp_eff - r_dv[NSTEP-1].q_a;
        n_f.frz   = ($signed(r_dv[NSTEP-1].temp) <= $signed(i_cfg.ft)) &&
                    (n_f.m >= {1'b0, i_cfg.ratio});
        n_f.hzero = r_dv[NSTEP-1].h == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (w_load[i]) begin
                    r_v[i] <= (i == 0) ? i_valid : r_v[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_a <= n_a;
        end
        if (w_load[1]) begin
            r_b <= n_b;
        end
        for (int i = 0; i < NSTEP; i++) begin
            if (w_load[i+2]) begin
                r_dv[i] <= n_dv[i];
            end
        end
        if (w_load[NST-1]) begin
            r_f <= n_f;
        end
    end

endmodule

FILE: rtl/rsplit_log.sv
module rsplit_log (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rsplit_pkg::t_mid i_mid,
    output logic             o_valid,
    input  logic             i_ready,
    output rsplit_pkg::t_lp  o_lp
);
    import rsplit_pkg::*;

    localparam int NST = NSTEP + 3;

    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic [15:0] coef;
        logic        frz;
        logic        hzero;
        logic        m_zero;
        logic        m_one;
        logic [15:0] alpha;
        logic [31:0] x;
        logic [4:0]  eint;
        logic [15:0] frac;
    } t_lg;

    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic [15:0] coef;
        logic        frz;
        logic        hzero;
        logic        m_zero;
        logic        m_one;
        logic [15:0] alpha;
        logic [20:0] e;
    } t_le;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_load;
    t_lg  r_l0, n_l0;
    t_lg  r_sq [NSTEP];
    t_lg  n_sq [NSTEP];
    t_lg  w_src [NSTEP];
    t_le  r_e, n_e;
    t_lp  r_p, n_p;
    logic [3:0]  w_b;
    logic [36:0] w_prod;

    always_comb begin
        w_load[NST-1] = !r_v[NST-1] || i_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_load[i] = !r_v[i] || w_load[i+1];
        end
    end

    assign o_ready = w_load[0];
    assign o_valid = r_v[NST-1];
    assign o_lp    = r_p;

    // Leading one sets the integer part; normalise the mantissa to Q1.31
    always_comb begin
        w_b = '0;
        for (int j = 0; j < 16; j++) begin
            if (i_mid.m[j]) begin
                w_b = 4'(j);
            end
        end
        n_l0.h      = i_mid.h;
        n_l0.rain   = i_mid.rain;
        n_l0.coef   = i_mid.coef;
        n_l0.frz    = i_mid.frz;
        n_l0.hzero  = i_mid.hzero;
        n_l0.m_zero = i_mid.m == '0;
        n_l0.m_one  = i_mid.m >= ONE_Q16;
        n_l0.alpha  = i_mid.alpha;
        n_l0.x      = 32'(i_mid.m[15:0]) << (5'd31 - {1'b0, w_b});
        n_l0.eint   = 5'd16 - {1'b0, w_b};
        n_l0.frac   = '0;
    end

    // One fraction bit per squaring
    generate
        for (genvar gi = 0; gi < NSTEP; gi++) begin : g_sq
            logic [63:0] w_sq;
            logic [32:0] w_s;
            if (gi == 0) begin : g_first
                assign w_src[gi] = r_l0;
            end else begin : g_next
                assign w_src[gi] = r_sq[gi-1];
            end
            assign w_sq = 64'(w_src[gi].x) * 64'(w_src[gi].x);
            assign w_s  = w_sq[63:31];
            always_comb begin
                n_sq[gi] = w_src[gi];
                if (w_s[32]) begin
                    n_sq[gi].x    = w_s[32:1];
                    n_sq[gi].frac = {w_src[gi].frac[14:0], 1'b1};
                end else begin
                    n_sq[gi].x    = w_s[31:0];
                    n_sq[gi].frac = {w_src[gi].frac[14:0], 1'b0};
                end
            end
        end
    endgenerate

    // Assemble -log2(m) in Q5.16
    always_comb begin
        n_e.h      = r_sq[NSTEP-1].h;
        n_e.rain   = r_sq[NSTEP-1].rain;
        n_e.coef   = r_sq[NSTEP-1].coef;
        n_e.frz    = r_sq[NSTEP-1].frz;
        n_e.hzero  = r_sq[NSTEP-1].hzero;
        n_e.m_zero = r_sq[NSTEP-1].m_zero;
        n_e.m_one  = r_sq[NSTEP-1].m_one;
        n_e.alpha  = r_sq[NSTEP-1].alpha;
        n_e.e      = {r_sq[NSTEP-1].eint, 16'b0} - {5'b0, r_sq[NSTEP-1].frac};
    end

    // Scale by the exponent alpha
    assign w_prod = 37'(r_e.e) * 37'(r_e.alpha);
    always_comb begin
        n_p.h      = r_e.h;
        n_p.rain   = r_e.rain;
        n_p.coef   = r_e.coef;
        n_p.frz    = r_e.frz;
        n_p.hzero  = r_e.hzero;
        n_p.m_zero = r_e.m_zero;
        n_p.m_one  = r_e.m_one;
        n_p.p      = w_prod[36:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (w_load[i]) begin
                    r_v[i] <= (i == 0) ? i_valid : r_v[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_l0 <= n_l0;
        end
        for (int i = 0; i < NSTEP; i++) begin
            if (w_load[i+1]) begin
                r_sq[i] <= n_sq[i];
            end
        end
        if (w_load[NST-2]) begin
            r_e <= n_e;
        end
        if (w_load[NST-1]) begin
            r_p <= n_p;
        end
    end

endmodule

FILE: rtl/rsplit_exp.sv
module rsplit_exp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rsplit_pkg::t_lp  i_lp,
    output logic             o_valid,
    input  logic             i_ready,
    output rsplit_pkg::t_res o_res
);
    import rsplit_pkg::*;

    localparam int NST = NSTEP + 4;

    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic [15:0] coef;
        logic        frz;
        logic        hzero;
        logic        m_zero;
        logic        m_one;
        logic [8:0]  n;
        logic [15:0] f;
        logic [32:0] r;
    } t_ex;

    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic [15:0] coef;
        logic        frz;
        logic        hzero;
        logic [16:0] pw;
    } t_pw;

    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic        frz;
        logic        hzero;
        logic [16:0] share;
    } t_sh;

    typedef struct packed {
        logic [24:0] h;
        logic [23:0] rain;
        logic        frz;
        logic        hzero;
        logic [24:0] ex;
    } t_xc;

    // 2^(-2^-i) in Q0.32: repeated integer square roots starting from 0.5
    function automatic logic [31:0] exp_factor(input int unsigned idx);
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] bv;
        t = 64'd1 << 31;
        for (int j = 0; j < 16; j++) begin
            if (j < idx) begin
                num = t << 32;
                res = '0;
                bv  = 64'd1 << 62;
                for (int s = 0; s < 32; s++) begin
                    if (num >= res + bv) begin
                        num = num - (res + bv);
                        res = (res >> 1) + bv;
                    end else begin
                        res = res >> 1;
                    end
                    bv = bv >> 2;
                end
                t = res;
            end
        end
        return t[31:0];
    endfunction

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_load;
    t_ex  r_mx [NSTEP];
    t_ex  n_mx [NSTEP];
    t_ex  w_src [NSTEP];
    t_ex  w_init;
    t_pw  r_pw, n_pw;
    t_sh  r_sh, n_sh;
    t_xc  r_xc, n_xc;
    t_res r_o, n_o;
    logic [32:0] w_rs;
    logic [32:0] w_cp;
    logic [41:0] w_hp;

    always_comb begin
        w_load[NST-1] = !r_v[NST-1] || i_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_load[i] = !r_v[i] || w_load[i+1];
        end
    end

    assign o_ready = w_load[0];
    assign o_valid = r_v[NST-1];
    assign o_res   = r_o;

    always_comb begin
        w_init.h      = i_lp.h;
        w_init.rain   = i_lp.rain;
        w_init.coef   = i_lp.coef;
        w_init.frz    = i_lp.frz;
        w_init.hzero  = i_lp.hzero;
        w_init.m_zero = i_lp.m_zero;
        w_init.m_one  = i_lp.m_one;
        w_init.n      = i_lp.p[24:16];
        w_init.f      = i_lp.p[15:0];
        w_init.r      = 33'd1 << 32;
    end

    // Multiply in one factor per set fraction bit
    generate
        for (genvar gi = 0; gi < NSTEP; gi++) begin : g_mul
            localparam logic [31:0] FAC = exp_factor(gi + 1);
            logic [64:0] w_m;
            if (gi == 0) begin : g_first
                assign w_src[gi] = w_init;
            end else begin : g_next
                assign w_src[gi] = r_mx[gi-1];
            end
            assign w_m = 65'(w_src[gi].r) * 65'(FAC);
            always_comb begin
                n_mx[gi] = w_src[gi];
                if (w_src[gi].f[NSTEP-1-gi]) begin
                    n_mx[gi].r = w_m[64:32];
                end
            end
        end
    endgenerate

    // Integer shift, scale to Q1.16, cap and special moisture values
    assign w_rs = r_mx[NSTEP-1].r >> r_mx[NSTEP-1].n[5:0];
    always_comb begin
        n_pw.h     = r_mx[NSTEP-1].h;
        n_pw.rain  = r_mx[NSTEP-1].rain;
        n_pw.coef  = r_mx[NSTEP-1].coef;
        n_pw.frz   = r_mx[NSTEP-1].frz;
        n_pw.hzero = r_mx[NSTEP-1].hzero;
        if (r_mx[NSTEP-1].m_zero) begin
            n_pw.pw = '0;
        end else if (r_mx[NSTEP-1].m_one) begin
            n_pw.pw = ONE_Q16;
        end else if (r_mx[NSTEP-1].n >= 9'd33) begin
            n_pw.pw = '0;
        end else if (w_rs[32:16] > ONE_Q16) begin
            n_pw.pw = ONE_Q16;
        end else begin
            n_pw.pw = w_rs[32:16];
        end
    end

    // Runoff share
    assign w_cp = 33'(r_pw.coef) * 33'(r_pw.pw);
    always_comb begin
        n_sh.h     = r_pw.h;
        n_sh.rain  = r_pw.rain;
        n_sh.frz   = r_pw.frz;
        n_sh.hzero = r_pw.hzero;
        n_sh.share = (r_pw.coef >= COEF_FULL) ? ONE_Q16 : w_cp[32:16];
    end

    // Excess depth, clipped to the water present
    assign w_hp = 42'(r_sh.h) * 42'(r_sh.share);
    always_comb begin
        n_xc.h     = r_sh.h;
        n_xc.rain  = r_sh.rain;
        n_xc.frz   = r_sh.frz;
        n_xc.hzero = r_sh.hzero;
        n_xc.ex    = (w_hp[41:16] > {1'b0, r_sh.h}) ? r_sh.h : w_hp[40:16];
    end

    // Apply the dry and frozen cases, split the water
    always_comb begin
        if (r_xc.hzero) begin
            n_o.excess_precip = '0;
            n_o.infiltration  = '0;
            n_o.frozen        = 1'b0;
        end else if (r_xc.frz) begin
            n_o.excess_precip = {1'b0, r_xc.rain};
            n_o.infiltration  = '0;
            n_o.frozen        = 1'b1;
        end else begin
            n_o.excess_precip = r_xc.ex;
            n_o.infiltration  = r_xc.h - r_xc.ex;
            n_o.frozen        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (w_load[i]) begin
                    r_v[i] <= (i == 0) ? i_valid : r_v[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSTEP; i++) begin
            if (w_load[i]) begin
                r_mx[i] <= n_mx[i];
            end
        end
        if (w_load[NSTEP]) begin
            r_pw <= n_pw;
        end
        if (w_load[NSTEP+1]) begin
            r_sh <= n_sh;
        end
        if (w_load[NSTEP+2]) begin
            r_xc <= n_xc;
        end
        if (w_load[NST-1]) begin
            r_o <= n_o;
        end
    end

endmodule
